FILE: src/task_slot_round_robin_scheduler_top_defines.svh
// Assertion macros used by the checker file.
`ifndef TASK_SLOT_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH
`define TASK_SLOT_ROUND_ROBIN_SCHEDULER_TOP_DEFINES_SVH

// Clocked check, switched off while reset is asserted.
`define TSRR_ASSERT(name, clk, rst_n, prop) \
    name: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error("%m: check failed");

// Clocked check that also runs during reset.
`define TSRR_ASSERT_ALWAYS(name, clk, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("%m: check failed");

`endif

FILE: src/tsrr_pkg.sv
package tsrr_pkg;

    // Table size and derived widths
    localparam int NUM_SLOTS  = 16;
    localparam int SLOT_IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

    // Fixed field widths
    localparam int FUNC_W   = 3;
    localparam int SLOT_W   = 4;
    localparam int STATUS_W = 2;

    // Request codes
    localparam logic [FUNC_W-1:0] FN_CREATE   = 3'd0;
    localparam logic [FUNC_W-1:0] FN_PAUSE    = 3'd1;
    localparam logic [FUNC_W-1:0] FN_RESUME   = 3'd2;
    localparam logic [FUNC_W-1:0] FN_KILL     = 3'd3;
    localparam logic [FUNC_W-1:0] FN_EXIT     = 3'd4;
    localparam logic [FUNC_W-1:0] FN_SCHEDULE = 3'd5;

    // Result status codes
    localparam logic [STATUS_W-1:0] STS_DONE    = 2'd0;
    localparam logic [STATUS_W-1:0] STS_NO_FREE = 2'd1;
    localparam logic [STATUS_W-1:0] STS_NO_RUN  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_IGNORED = 2'd3;

    // Per-slot state codes
    typedef logic [1:0] t_slot_state;
    localparam t_slot_state SS_UNUSED   = 2'd0;
    localparam t_slot_state SS_RUNNABLE = 2'd1;
    localparam t_slot_state SS_PAUSED   = 2'd2;
    localparam t_slot_state SS_DEAD     = 2'd3;

    // One result transaction
    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   chosen_slot;
        logic                alive;
        logic                killed_flag;
    } t_result;

    // Index of the lowest set bit (zero when none is set)
    function automatic logic [SLOT_IDX_W-1:0] first_set(input logic [NUM_SLOTS-1:0] vec);
        logic [NUM_SLOTS-1:0]  lowest;
        logic [SLOT_IDX_W-1:0] idx;
        lowest = vec & (~vec + NUM_SLOTS'(1));
        idx    = '0;
        for (int i = 0; i < NUM_SLOTS; i++) begin
            if (lowest[i]) begin
                idx = idx | SLOT_IDX_W'(i);
            end
        end
        return idx;
    endfunction

endpackage

FILE: src/tsrr_pick.sv
// Rotating priority encoder: first runnable slot after the start position.
module tsrr_pick import tsrr_pkg::*; (
    input  logic [NUM_SLOTS-1:0]  i_runnable,
    input  logic [SLOT_IDX_W-1:0] i_start,
    output logic                  o_found,
    output logic [SLOT_IDX_W-1:0] o_idx
);

    logic [NUM_SLOTS-1:0] above_mask;
    logic [NUM_SLOTS-1:0] above;

    // Slots strictly above the start position win first
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            above_mask[i] = (i > int'(i_start));
        end
    end

    assign above   = i_runnable & above_mask;
    assign o_found = |i_runnable;
    // Wrap around to the bottom when nothing above is runnable
    assign o_idx   = (|above) ? first_set(above) : first_set(i_runnable);

endmodule

FILE: src/tsrr_table.sv
// Slot table: per-slot state, kill marks, round-robin position and request decode.
module tsrr_table import tsrr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [FUNC_W-1:0] i_func,
    input  logic [SLOT_W-1:0] i_slot,
    output t_result           o_result
);

    t_slot_state           r_state [NUM_SLOTS];
    t_slot_state           n_state [NUM_SLOTS];
    logic [NUM_SLOTS-1:0]  r_kill;
    logic [NUM_SLOTS-1:0]  n_kill;
    logic [SLOT_W-1:0]     r_rr;
    logic [SLOT_W-1:0]     n_rr;

    logic [NUM_SLOTS-1:0]  free_vec;
    logic [NUM_SLOTS-1:0]  run_vec;
    logic                  free_any;
    logic [SLOT_IDX_W-1:0] free_idx;
    logic                  pick_found;
    logic [SLOT_IDX_W-1:0] pick_idx;

    logic                  in_range;
    logic [SLOT_IDX_W-1:0] sidx;
    t_slot_state           cur_st;
    logic                  cur_alive;
    logic                  cur_kill;

    // Per-slot summaries for the encoders
    always_comb begin
        for (int i = 0; i < NUM_SLOTS; i++) begin
            free_vec[i] = (r_state[i] == SS_UNUSED);
            run_vec[i]  = (r_state[i] == SS_RUNNABLE);
        end
    end

    assign free_any = |free_vec;
    assign free_idx = first_set(free_vec);

    tsrr_pick u_pick (
        .i_runnable (run_vec),
        .i_start    (SLOT_IDX_W'(r_rr)),
        .o_found    (pick_found),
        .o_idx      (pick_idx)
    );

    // Targeted slot as it stands now; out-of-range slots read as unused
    assign in_range  = (32'(i_slot) < NUM_SLOTS);
    assign sidx      = SLOT_IDX_W'(i_slot);
    assign cur_st    = in_range ? r_state[sidx] : SS_UNUSED;
    assign cur_kill  = in_range ? r_kill[sidx] : 1'b0;
    assign cur_alive = (cur_st == SS_RUNNABLE) || (cur_st == SS_PAUSED);

    // Request decode: next table state and the result
    always_comb begin
        n_state = r_state;
        n_kill  = r_kill;
        n_rr    = r_rr;
        o_result.status      = STS_IGNORED;
        o_result.chosen_slot = i_slot;
        o_result.alive       = cur_alive;
        o_result.killed_flag = cur_kill;
        unique case (i_func)
            FN_CREATE: begin
                o_result.chosen_slot = '0;
                o_result.alive       = 1'b0;
                o_result.killed_flag = 1'b0;
                o_result.status      = STS_NO_FREE;
                if (free_any) begin
                    n_state[free_idx]    = SS_RUNNABLE;
                    n_kill[free_idx]     = 1'b0;
                    o_result.status      = STS_DONE;
                    o_result.chosen_slot = SLOT_W'(free_idx);
                    o_result.alive       = 1'b1;
                end
            end
            FN_SCHEDULE: begin
                o_result.chosen_slot = '0;
                o_result.alive       = 1'b0;
                o_result.killed_flag = 1'b0;
                o_result.status      = STS_NO_RUN;
                if (pick_found) begin
                    n_rr                 = SLOT_W'(pick_idx);
                    o_result.status      = STS_DONE;
                    o_result.chosen_slot = SLOT_W'(pick_idx);
                    o_result.alive       = 1'b1;
                    o_result.killed_flag = r_kill[pick_idx];
                end
            end
            FN_PAUSE, FN_RESUME: begin
                if (in_range && cur_alive) begin
                    n_state[sidx]   = (i_func == FN_PAUSE) ? SS_PAUSED : SS_RUNNABLE;
                    o_result.status = STS_DONE;
                    o_result.alive  = 1'b1;
                end
            end
            FN_KILL: begin
                if (in_range) begin
                    n_kill[sidx] = 1'b1;
                    if (cur_st == SS_PAUSED) begin
                        n_state[sidx] = SS_RUNNABLE;
                    end
                    o_result.status      = STS_DONE;
                    o_result.killed_flag = 1'b1;
                end
            end
            FN_EXIT: begin
                if (in_range) begin
                    n_state[sidx]   = SS_DEAD;
                    o_result.status = STS_DONE;
                    o_result.alive  = 1'b0;
                end
            end
            default: ;
        endcase
    end

    // Table registers, updated once per advanced transaction
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= '{default: SS_UNUSED};
            r_kill  <= '0;
            r_rr    <= '0;
        end else if (i_en) begin
            r_state <= n_state;
            r_kill  <= n_kill;
            r_rr    <= n_rr;
        end
    end

endmodule

FILE: src/task_slot_round_robin_scheduler_top.sv
// Task slot round-robin scheduler.
// A request is held in the input register, then passes through the slot table into the result register.
// Throughput: one request per cycle while the output is not stalled; the slot table update
// and the rotating priority encoder are combinational between the input and result registers.
// Reset (synchronous, active low): all slots unused, kill marks and position zero,
// both pipeline registers empty.
module task_slot_round_robin_scheduler_top import tsrr_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [FUNC_W-1:0]   i_func,
    input  logic [SLOT_W-1:0]   i_slot,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [STATUS_W-1:0] o_status,
    output logic [SLOT_W-1:0]   o_chosen_slot,
    output logic                o_alive,
    output logic                o_killed_flag
);

    logic              r_in_valid;
    logic [FUNC_W-1:0] r_func;
    logic [SLOT_W-1:0] r_slot;
    logic              r_out_valid;
    t_result           r_res;
    t_result           table_res;
    logic              advance;

    // Move the held request into the result register when that slot frees up
    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    tsrr_table u_table (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (advance),
        .i_func   (r_func),
        .i_slot   (r_slot),
        .o_result (table_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_func <= i_func;
            r_slot <= i_slot;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_res <= table_res;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_res.status;
    assign o_chosen_slot = r_res.chosen_slot;
    assign o_alive       = r_res.alive;
    assign o_killed_flag = r_res.killed_flag;

endmodule

FILE: src/tsrr_checker.sv
`include "task_slot_round_robin_scheduler_top_defines.svh"

// Port-level checks on the scheduler top level.
module tsrr_checker import tsrr_pkg::*; (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input logic [STATUS_W-1:0] o_status,
    input logic [SLOT_W-1:0]   o_chosen_slot,
    input logic                o_alive,
    input logic                o_killed_flag
);

    // Reset empties the pipeline and opens the input
    `TSRR_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> o_in_ready && !o_out_valid)

    // A stalled result transaction holds its payload
    `TSRR_ASSERT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready |=> o_out_valid && $stable(o_status) && $stable(o_chosen_slot) && $stable(o_alive) && $stable(o_killed_flag))

    // A full table reports nothing about any slot
    `TSRR_ASSERT(a_no_free_zero, i_clk, i_rst_n, o_out_valid && o_status == STS_NO_FREE |-> o_chosen_slot == '0 && !o_alive && !o_killed_flag)

    // An idle schedule reports nothing about any slot
    `TSRR_ASSERT(a_no_run_zero, i_clk, i_rst_n, o_out_valid && o_status == STS_NO_RUN |-> o_chosen_slot == '0 && !o_alive && !o_killed_flag)

endmodule

bind task_slot_round_robin_scheduler_top tsrr_checker u_tsrr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_chosen_slot (o_chosen_slot),
    .o_alive       (o_alive),
    .o_killed_flag (o_killed_flag)
);
